>>> hw/rtl/pnt_pkg.sv
`default_nettype none
package pnt_pkg;

  localparam int unsigned NameW   = 112;
  localparam int unsigned NameLoW = 64;
  localparam int unsigned NameHiW = 48;
  localparam int unsigned StatW   = 3;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned UserW   = 3;
  localparam int unsigned NameBytes = 14;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_LIST   = 2'd1,
    OP_DELETE = 2'd2,
    OP_SEARCH = 2'd3
  } pnt_op_e;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4
  } pnt_status_e;

  // where the entry_index of a result comes from
  typedef enum logic [1:0] {
    ISRC_ZERO  = 2'd0,
    ISRC_POS   = 2'd1,
    ISRC_COUNT = 2'd2,
    ISRC_IDX   = 2'd3
  } pnt_isrc_e;

  typedef struct packed {
    logic        capture;
    logic        idx_inc;
    logic        rd_scan;
    logic        rd_next;
    logic        wr_append;
    logic        wr_shift;
    logic        cnt_inc;
    logic        cnt_dec;
    logic        save_pos;
    logic        out_load;
    logic        out_entry;
    logic        out_last;
    pnt_status_e out_status;
    pnt_isrc_e   out_isrc;
  } pnt_cmd_t;

  typedef struct packed {
    pnt_op_e op;
    logic    valid;
    logic    full;
    logic    empty;
    logic    at_end;
    logic    match;
    logic    shift_done;
    logic    list_last;
    logic    out_free;
  } pnt_stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/per_user_name_table_top.sv
// Channel   Dir  Handshake         Payload
// s_axis    in   tvalid / tready   tdata: command, user_id, name_low, name_high
// m_axis    out  tvalid / tready   tdata: status, entry_low, entry_high, entry_index;
//                                  tlast: last
//
// One request at a time. Create, delete and search compare the stored entries in order,
// each with a store read and then a compare; delete then moves each later entry down.
// List reads and sends each entry in turn; an empty list gives a single ST_EMPTY result.
// The name store, with its single read port, sets this order of steps.
// Reset clears the per-user counts at once; no clearing pass.
// A full output register stalls the walk until m_axis_tready_i is high.
`default_nettype none
module per_user_name_table_top #(
  parameter int unsigned USERS = 8,
  parameter int unsigned SLOTS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // lowest first: command[1:0], user_id[4:2], name_low[68:5], name_high[116:69]
  input  wire logic [119:0] s_axis_tdata_i,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // lowest first: status[2:0], entry_low[66:3], entry_high[114:67],
  // entry_index[118:115]
  output logic      [119:0] m_axis_tdata_o,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic              m_axis_tlast_o
);
  import pnt_pkg::*;

  pnt_cmd_t          cmd;
  pnt_stat_t         stat;
  logic [StatW-1:0]  out_status;
  logic [NameLoW-1:0] out_lo;
  logic [NameHiW-1:0] out_hi;
  logic [IdxW-1:0]   out_idx;

  pnt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pnt_datapath #(
    .USERS (USERS),
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .in_command_i      (s_axis_tdata_i[1:0]),
    .in_user_id_i      (s_axis_tdata_i[4:2]),
    .in_name_low_i     (s_axis_tdata_i[68:5]),
    .in_name_high_i    (s_axis_tdata_i[116:69]),
    .out_ready_i       (m_axis_tready_i),
    .out_valid_o       (m_axis_tvalid_o),
    .out_status_o      (out_status),
    .out_entry_low_o   (out_lo),
    .out_entry_high_o  (out_hi),
    .out_entry_index_o (out_idx),
    .out_last_o        (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {1'b0, out_idx, out_hi, out_lo, out_status};

  a_append_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_append |-> (stat.valid && !stat.full))
    else $error("append into a full or invalid list");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |=> !s_axis_tready_o)
    else $error("second transaction taken while one is in work");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> stat.out_free)
    else $error("output register overwritten");

  a_dec_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.cnt_dec |-> !stat.empty)
    else $error("count decrement on empty list");

endmodule
`default_nettype wire

>>> hw/rtl/pnt_ram.sv
`default_nettype none
module pnt_ram #(
  parameter int unsigned WIDTH = 112,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> hw/rtl/pnt_ctrl.sv
`default_nettype none
module pnt_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire pnt_pkg::pnt_stat_t stat_i,
  output pnt_pkg::pnt_cmd_t       cmd_o
);
  import pnt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_SCAN, S_CMP, S_SH_RD, S_SH_WR, S_LRD, S_LWAIT
  } state_e;

  typedef enum logic {
    E_NONE, E_PEND
  } emit_e;

  state_e      state_q, state_d;
  logic        emit_q, emit_d;
  pnt_status_e res_status_q, res_status_d;
  pnt_isrc_e   res_isrc_q, res_isrc_d;
  pnt_cmd_t    cmd;

  always_comb begin
    state_d      = state_q;
    emit_d       = emit_q;
    res_status_d = res_status_q;
    res_isrc_d   = res_isrc_q;
    cmd          = '0;
    cmd.out_status = ST_DONE;
    cmd.out_isrc   = ISRC_ZERO;

    // a finished single result waits here for the output register
    if (emit_q) begin
      if (stat_i.out_free) begin
        cmd.out_load   = 1'b1;
        cmd.out_last   = 1'b1;
        cmd.out_status = res_status_q;
        cmd.out_isrc   = res_isrc_q;
        emit_d         = 1'b0;
        state_d        = S_IDLE;
      end
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd.capture = 1'b1;
            state_d     = S_START;
          end
        end
        S_START: begin
          if (stat_i.op == OP_LIST) begin
            if (stat_i.empty) begin
              res_status_d = ST_EMPTY;
              res_isrc_d   = ISRC_ZERO;
              emit_d       = 1'b1;
            end else begin
              state_d = S_LRD;
            end
          end else begin
            state_d = S_SCAN;
          end
        end
        S_SCAN: begin
          if (stat_i.at_end) begin
            emit_d = 1'b1;
            if (stat_i.op == OP_CREATE) begin
              if (!stat_i.valid || stat_i.full) begin
                res_status_d = ST_FULL;
                res_isrc_d   = ISRC_ZERO;
              end else begin
                cmd.wr_append = 1'b1;
                cmd.cnt_inc   = 1'b1;
                res_status_d  = ST_DONE;
                res_isrc_d    = ISRC_COUNT;
              end
            end else begin
              res_status_d = ST_NOTFOUND;
              res_isrc_d   = ISRC_ZERO;
            end
          end else begin
            cmd.rd_scan = 1'b1;
            state_d     = S_CMP;
          end
        end
        S_CMP: begin
          if (stat_i.match) begin
            cmd.save_pos = 1'b1;
            res_isrc_d   = ISRC_POS;
            case (stat_i.op)
              OP_CREATE: begin
                res_status_d = ST_DUP;
                emit_d       = 1'b1;
              end
              OP_DELETE: begin
                res_status_d = ST_DONE;
                state_d      = S_SH_RD;
              end
              default: begin
                res_status_d = ST_DONE;
                emit_d       = 1'b1;
              end
            endcase
          end else begin
            cmd.idx_inc = 1'b1;
            state_d     = S_SCAN;
          end
        end
        S_SH_RD: begin
          if (stat_i.shift_done) begin
            cmd.cnt_dec = 1'b1;
            emit_d      = 1'b1;
          end else begin
            cmd.rd_next = 1'b1;
            state_d     = S_SH_WR;
          end
        end
        S_SH_WR: begin
          cmd.wr_shift = 1'b1;
          cmd.idx_inc  = 1'b1;
          state_d      = S_SH_RD;
        end
        S_LRD: begin
          cmd.rd_scan = 1'b1;
          state_d     = S_LWAIT;
        end
        S_LWAIT: begin
          if (stat_i.out_free) begin
            cmd.out_load   = 1'b1;
            cmd.out_entry  = 1'b1;
            cmd.out_last   = stat_i.list_last;
            cmd.out_status = ST_DONE;
            cmd.out_isrc   = ISRC_IDX;
            if (stat_i.list_last) begin
              state_d = S_IDLE;
            end else begin
              cmd.idx_inc = 1'b1;
              state_d     = S_LRD;
            end
          end
        end
        default: begin
          state_d = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      emit_q       <= E_NONE;
      res_status_q <= ST_DONE;
      res_isrc_q   <= ISRC_ZERO;
    end else begin
      state_q      <= state_d;
      emit_q       <= emit_d;
      res_status_q <= res_status_d;
      res_isrc_q   <= res_isrc_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE) && !emit_q;
  assign cmd_o      = cmd;

endmodule
`default_nettype wire

>>> hw/rtl/pnt_datapath.sv
`default_nettype none
module pnt_datapath #(
  parameter int unsigned USERS = 8,
  parameter int unsigned SLOTS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire pnt_pkg::pnt_cmd_t             cmd_i,
  output pnt_pkg::pnt_stat_t                 stat_o,
  input  wire logic [1:0]                    in_command_i,
  input  wire logic [pnt_pkg::UserW-1:0]     in_user_id_i,
  input  wire logic [pnt_pkg::NameLoW-1:0]   in_name_low_i,
  input  wire logic [pnt_pkg::NameHiW-1:0]   in_name_high_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic [pnt_pkg::StatW-1:0]          out_status_o,
  output logic [pnt_pkg::NameLoW-1:0]        out_entry_low_o,
  output logic [pnt_pkg::NameHiW-1:0]        out_entry_high_o,
  output logic [pnt_pkg::IdxW-1:0]           out_entry_index_o,
  output logic                               out_last_o
);
  import pnt_pkg::*;

  localparam int unsigned Depth = USERS * SLOTS;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW    = $clog2(SLOTS + 1);
  localparam int unsigned UIW   = (USERS > 1) ? $clog2(USERS) : 1;

  pnt_op_e          op_q;
  logic [NameW-1:0] name_q;
  logic [UIW-1:0]   uidx_q;
  logic             valid_q;
  logic [AW-1:0]    base_q;
  logic [CW-1:0]    cnt_lat_q;
  logic [CW-1:0]    idx_q;
  logic [CW-1:0]    pos_q;
  logic [CW-1:0]    cnt_q [USERS];

  logic             out_valid_q;
  logic [StatW-1:0] out_status_q;
  logic [NameW-1:0] out_entry_q;
  logic [IdxW-1:0]  out_index_q;
  logic             out_last_q;

  logic [NameW-1:0] name_raw, name_canon;
  logic [7:0]       user_ext;
  logic             user_ok;
  logic [UIW-1:0]   uidx;
  logic             alive;
  logic [7:0]       nbyte;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [NameW-1:0] ram_wdata, ram_rdata;
  logic [CW:0]      idx_nxt;
  logic [CW-1:0]    idx_sel;
  logic             out_free;

  // the name ends at its first zero byte; clear everything after it
  always_comb begin
    name_raw   = {in_name_high_i, in_name_low_i};
    name_canon = '0;
    alive      = 1'b1;
    nbyte      = '0;
    for (int b = 0; b < NameBytes; b++) begin
      nbyte = name_raw[b*8 +: 8];
      if (alive) begin
        name_canon[b*8 +: 8] = nbyte;
      end
      if (nbyte == 8'd0) begin
        alive = 1'b0;
      end
    end
  end

  assign user_ext = 8'(in_user_id_i);
  assign user_ok  = user_ext < 8'(USERS);
  assign uidx     = user_ext[UIW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= pnt_op_e'(in_command_i);
      name_q    <= name_canon;
      uidx_q    <= uidx;
      valid_q   <= user_ok;
      base_q    <= user_ok ? AW'(uidx * SLOTS) : '0;
      cnt_lat_q <= user_ok ? cnt_q[uidx] : '0;
    end
    if (cmd_i.capture) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + 1'b1;
    end
    if (cmd_i.save_pos) begin
      pos_q <= idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int u = 0; u < USERS; u++) begin
        cnt_q[u] <= '0;
      end
    end else if (cmd_i.cnt_inc) begin
      cnt_q[uidx_q] <= cnt_lat_q + 1'b1;
    end else if (cmd_i.cnt_dec) begin
      cnt_q[uidx_q] <= cnt_lat_q - 1'b1;
    end
  end

  assign ram_re    = cmd_i.rd_scan || cmd_i.rd_next;
  assign ram_raddr = base_q + AW'(idx_q) + AW'(cmd_i.rd_next);
  assign ram_we    = cmd_i.wr_append || cmd_i.wr_shift;
  assign ram_waddr = cmd_i.wr_append ? base_q + AW'(cnt_lat_q) : base_q + AW'(idx_q);
  assign ram_wdata = cmd_i.wr_append ? name_q : ram_rdata;

  pnt_ram #(
    .WIDTH (NameW),
    .DEPTH (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign idx_nxt  = (CW+1)'(idx_q) + 1'b1;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    stat_o.op         = op_q;
    stat_o.valid      = valid_q;
    stat_o.full       = cnt_lat_q >= CW'(SLOTS);
    stat_o.empty      = cnt_lat_q == '0;
    stat_o.at_end     = idx_q == cnt_lat_q;
    stat_o.match      = ram_rdata == name_q;
    stat_o.shift_done = idx_nxt >= (CW+1)'(cnt_lat_q);
    stat_o.list_last  = idx_nxt == (CW+1)'(cnt_lat_q);
    stat_o.out_free   = out_free;
  end

  always_comb begin
    case (cmd_i.out_isrc)
      ISRC_POS:   idx_sel = pos_q;
      ISRC_COUNT: idx_sel = cnt_lat_q;
      ISRC_IDX:   idx_sel = idx_q;
      default:    idx_sel = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.out_status;
      out_entry_q  <= cmd_i.out_entry ? ram_rdata : '0;
      out_index_q  <= IdxW'(idx_sel);
      out_last_q   <= cmd_i.out_last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_status_o      = out_status_q;
  assign out_entry_low_o   = out_entry_q[NameLoW-1:0];
  assign out_entry_high_o  = out_entry_q[NameW-1:NameLoW];
  assign out_entry_index_o = out_index_q;
  assign out_last_o        = out_last_q;

endmodule
`default_nettype wire
